// ===== rtl/core/s2cd_pkg.sv =====
// constants and helper tables for the seconds to calendar date converter
// used by seconds_to_calendar_date; no dependencies
`timescale 1ns / 1ps

package s2cd_pkg;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned BaseYear    = 2000;
  localparam int unsigned DaysPerQuad = 1461;

  // register stages of the converter pipeline
  localparam int NSTAGE = 10;

  // day index of 2100-03-01; from there on one day is added so that the
  // plain four-year cycle also covers the missing 29 february 2100
  localparam logic [15:0] SKIP_2100 = 16'd36584;

  // reciprocals, rounded down; each quotient estimate is low by at most one
  localparam logic [31:0] RECIP_DAY  = 32'd3257812230; // 2^41 / 675, after >> 7
  localparam int          SHIFT_DAY  = 41;
  localparam logic [16:0] RECIP_HOUR = 17'd74565;      // 2^28 / 3600
  localparam int          SHIFT_HOUR = 28;
  localparam logic [15:0] RECIP_QUAD = 16'd45933;      // 2^26 / 1461
  localparam int          SHIFT_QUAD = 26;
  localparam logic [12:0] RECIP_MIN  = 13'd4369;       // 2^18 / 60
  localparam int          SHIFT_MIN  = 18;

  localparam logic [3:0] NUM_MONTHS = 4'd12;

  // first day of the year in a four-year cycle that starts with a leap year
  function automatic logic [10:0] year_start(input logic [1:0] y);
    logic [10:0] s;
    case (y)
      2'd0:    s = 11'd0;
      2'd1:    s = 11'd366;
      2'd2:    s = 11'd731;
      2'd3:    s = 11'd1096;
      default: s = 11'd0;
    endcase
    return s;
  endfunction

  // first day of month m (0 = january) within the year
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/seconds_to_calendar_date.sv =====
// seconds since 2000-01-01 00:00:00 utc to gregorian date and time of day
// ten-stage pipeline built from constant-reciprocal divisions; uses s2cd_pkg
`timescale 1ns / 1ps

//  channel  | direction | tdata fields (lowest bit first)
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | utc_seconds[31:0]
//  m_*      | out       | year[11:0] month[15:12] day_of_month[20:16]
//           |           | hour[25:21] minute[31:26] second[37:32], zero fill
//
//  one item per cycle sustained while m_tready stays high; the
//  ten register stages hold multiplies and subtract and compare steps,
//  and no state is kept between items
//  rst clears the stage valid bits only; the data registers are not reset
//  each stage holds while its successor is full and stalled, so a stall on
//  m_tready backs up stage by stage and empty stages still fill meanwhile

module seconds_to_calendar_date
  import s2cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // utc_seconds[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // year, month, day_of_month, hour, minute, second
);

  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] en;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[NSTAGE+1] = m_tready;
    for (int k = NSTAGE; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: day quotient product, seconds / 86400 = (seconds >> 7) / 675
  logic [31:0] t1;
  logic [56:0] p1;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1 <= s_tdata;
      p1 <= 57'(s_tdata[31:7]) * 57'(RECIP_DAY);
    end
  end

  // stage 2: day estimate and its seconds back
  logic [31:0] t2;
  logic [15:0] d2;
  logic [32:0] p2;
  logic [15:0] d2_next;
  assign d2_next = p1[SHIFT_DAY +: 16];
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t2 <= t1;
      d2 <= d2_next;
      p2 <= 33'(d2_next) * 33'(SecsPerDay);
    end
  end

  // stage 3: time of day, estimate corrected by one day where needed
  logic [16:0] tod3;
  logic [15:0] d3;
  logic [32:0] diff3;
  logic [17:0] tode3;
  assign diff3 = {1'b0, t2} - p2;
  assign tode3 = diff3[17:0];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (tode3 >= 18'(SecsPerDay)) begin
        tod3 <= 17'(tode3 - 18'(SecsPerDay));
        d3   <= d2 + 16'd1;
      end else begin
        tod3 <= tode3[16:0];
        d3   <= d2;
      end
    end
  end

  // stage 4: insert the missing leap day of 2100, hour product
  logic [16:0] tod4;
  logic [15:0] dd4;
  logic [33:0] ph4;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      tod4 <= tod3;
      dd4  <= (d3 >= SKIP_2100) ? d3 + 16'd1 : d3;
      ph4  <= 34'(tod3) * 34'(RECIP_HOUR);
    end
  end

  // stage 5: hour estimate back to seconds, four-year cycle product
  logic [16:0] tod5;
  logic [15:0] dd5;
  logic [4:0]  h5;
  logic [16:0] ph5;
  logic [31:0] pq5;
  logic [4:0]  h5_next;
  assign h5_next = ph4[SHIFT_HOUR +: 5];
  always_ff @(posedge clk) begin
    if (en[5]) begin
      tod5 <= tod4;
      dd5  <= dd4;
      h5   <= h5_next;
      ph5  <= 17'(h5_next) * 17'(SecsPerHour);
      pq5  <= 32'(dd4) * 32'(RECIP_QUAD);
    end
  end

  // stage 6: corrected hour and seconds of the hour, cycle estimate back to days
  logic [4:0]  hr6;
  logic [11:0] rem6;
  logic [15:0] dd6;
  logic [5:0]  q6;
  logic [15:0] pq6;
  logic [12:0] reme6;
  logic [5:0]  q6_next;
  assign reme6   = 13'(tod5 - ph5);
  assign q6_next = pq5[SHIFT_QUAD +: 6];
  always_ff @(posedge clk) begin
    if (en[6]) begin
      if (reme6 >= 13'(SecsPerHour)) begin
        hr6  <= h5 + 5'd1;
        rem6 <= 12'(reme6 - 13'(SecsPerHour));
      end else begin
        hr6  <= h5;
        rem6 <= reme6[11:0];
      end
      dd6 <= dd5;
      q6  <= q6_next;
      pq6 <= 16'(q6_next) * 16'(DaysPerQuad);
    end
  end

  // stage 7: corrected cycle count and day within the cycle, minute product
  logic [4:0]  hr7;
  logic [11:0] rem7;
  logic [5:0]  q7;
  logic [10:0] r7;
  logic [24:0] pm7;
  logic [11:0] re7;
  assign re7 = 12'(dd6 - pq6);
  always_ff @(posedge clk) begin
    if (en[7]) begin
      hr7  <= hr6;
      rem7 <= rem6;
      if (re7 >= 12'(DaysPerQuad)) begin
        q7 <= q6 + 6'd1;
        r7 <= 11'(re7 - 12'(DaysPerQuad));
      end else begin
        q7 <= q6;
        r7 <= re7[10:0];
      end
      pm7 <= 25'(rem6) * 25'(RECIP_MIN);
    end
  end

  // stage 8: year within the cycle, minute estimate back to seconds
  logic [4:0]  hr8;
  logic [11:0] rem8;
  logic [5:0]  q8;
  logic [10:0] r8;
  logic [1:0]  y8;
  logic [5:0]  m8;
  logic [11:0] pm8;
  logic [5:0]  m8_next;
  assign m8_next = pm7[SHIFT_MIN +: 6];
  always_ff @(posedge clk) begin
    if (en[8]) begin
      hr8  <= hr7;
      rem8 <= rem7;
      q8   <= q7;
      r8   <= r7;
      y8   <= 2'(r7 >= year_start(2'd1)) + 2'(r7 >= year_start(2'd2))
            + 2'(r7 >= year_start(2'd3));
      m8   <= m8_next;
      pm8  <= 12'(m8_next) * 12'(SecsPerMin);
    end
  end

  // stage 9: corrected minute and second, day of year, calendar year
  logic [4:0]  hr9;
  logic [5:0]  mn9;
  logic [5:0]  sc9;
  logic [8:0]  doy9;
  logic        leap9;
  logic [11:0] yr9;
  logic [6:0]  sce9;
  logic [10:0] doy9_next;
  assign sce9      = 7'(rem8 - pm8);
  assign doy9_next = r8 - year_start(y8);
  always_ff @(posedge clk) begin
    if (en[9]) begin
      hr9 <= hr8;
      if (sce9 >= 7'(SecsPerMin)) begin
        mn9 <= m8 + 6'd1;
        sc9 <= 6'(sce9 - 7'(SecsPerMin));
      end else begin
        mn9 <= m8;
        sc9 <= sce9[5:0];
      end
      doy9  <= doy9_next[8:0];
      leap9 <= (y8 == 2'd0);
      yr9   <= 12'(BaseYear) + {4'd0, q8, y8};
    end
  end

  // stage 10: month by table compare, day of month; output register
  logic [11:0] yr10;
  logic [3:0]  mo10;
  logic [4:0]  day10;
  logic [4:0]  hr10;
  logic [5:0]  mn10;
  logic [5:0]  sc10;
  logic [3:0]  mi9;
  logic [8:0]  dom9;

  always_comb begin
    mi9 = 4'd0;
    for (int m = 1; m < int'(NUM_MONTHS); m++) begin
      if (doy9 >= month_start(4'(m), leap9)) begin
        mi9 = 4'(m);
      end
    end
    dom9 = doy9 - month_start(mi9, leap9) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      yr10  <= yr9;
      mo10  <= mi9 + 4'd1;
      day10 <= dom9[4:0];
      hr10  <= hr9;
      mn10  <= mn9;
      sc10  <= sc9;
    end
  end

  assign m_tdata = {2'b00, sc10, mn10, hr10, day10, mo10, yr10};

endmodule
